FILE: sv/asst_pkg.sv
package asst_pkg;

  // anchor packet type code
  localparam logic [7:0] AnchorCode = 8'hA1;
  // shortest payload that carries a full anchor header
  localparam logic [5:0] MinLength = 6'd8;
  // reset values of the running min and max trackers
  localparam logic signed [31:0] S32Max = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32Min = 32'sh8000_0000;

  // one received packet header plus local receive time
  typedef struct packed {
    logic [7:0]  packet_type;
    logic [5:0]  pkt_len;
    logic [7:0]  rx_session_tag;
    logic [7:0]  sequence_req;
    logic [31:0] master_time;
    logic [31:0] local_time;
  } req_t;

  // one result per packet
  typedef struct packed {
    logic               accepted;
    logic signed [31:0] offset;
    logic signed [31:0] offset_min;
    logic signed [31:0] offset_max;
    logic signed [31:0] master_delta;
    logic signed [31:0] local_delta;
    logic signed [31:0] skew;
    logic signed [31:0] skew_min;
    logic signed [31:0] skew_max;
    logic signed [31:0] max_master_delta;
    logic [31:0]        gap_count;
    logic [31:0]        missing_total;
  } res_t;

endpackage

FILE: sv/asst_filter.sv
module asst_filter (
  input  asst_pkg::req_t req_i,
  input  logic [7:0]     session_tag_i,
  output logic           ok_o
);

  // anchor check: length, type code and session tag
  assign ok_o = (req_i.pkt_len >= asst_pkg::MinLength) &&
                (req_i.packet_type == asst_pkg::AnchorCode) &&
                (req_i.rx_session_tag == session_tag_i);

endmodule

FILE: sv/asst_stats.sv
module asst_stats (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           ok_i,
  input  asst_pkg::req_t req_i,
  output asst_pkg::res_t res_o
);

  logic               seq_known_q, seq_known_d;
  logic [7:0]         exp_seq_q, exp_seq_d;
  logic               times_known_q, times_known_d;
  logic [31:0]        prev_m_q, prev_m_d;
  logic [31:0]        prev_l_q, prev_l_d;
  logic signed [31:0] offset_q, offset_d;
  logic signed [31:0] off_min_q, off_min_d;
  logic signed [31:0] off_max_q, off_max_d;
  logic signed [31:0] md_q, md_d;
  logic signed [31:0] ld_q, ld_d;
  logic signed [31:0] skew_q, skew_d;
  logic signed [31:0] skew_min_q, skew_min_d;
  logic signed [31:0] skew_max_q, skew_max_d;
  logic signed [31:0] peak_md_q, peak_md_d;
  logic [31:0]        gaps_q, gaps_d;
  logic [31:0]        missing_q, missing_d;

  logic [7:0]         seq_jump;
  logic signed [31:0] new_off, new_md, new_ld, new_skew;

  // wrapping differences of the current request
  assign seq_jump = req_i.sequence_req - exp_seq_q;
  assign new_off  = $signed(req_i.local_time - req_i.master_time);
  assign new_md   = $signed(req_i.master_time - prev_m_q);
  assign new_ld   = $signed(req_i.local_time - prev_l_q);
  assign new_skew = new_ld - new_md;

  // next state, unchanged for a rejected packet
  always_comb begin
    seq_known_d   = seq_known_q;
    exp_seq_d     = exp_seq_q;
    times_known_d = times_known_q;
    prev_m_d      = prev_m_q;
    prev_l_d      = prev_l_q;
    offset_d      = offset_q;
    off_min_d     = off_min_q;
    off_max_d     = off_max_q;
    md_d          = md_q;
    ld_d          = ld_q;
    skew_d        = skew_q;
    skew_min_d    = skew_min_q;
    skew_max_d    = skew_max_q;
    peak_md_d     = peak_md_q;
    gaps_d        = gaps_q;
    missing_d     = missing_q;
    if (ok_i) begin
      // sequence gap accounting
      if (seq_known_q && (seq_jump != 8'd0)) begin
        gaps_d    = gaps_q + 32'd1;
        missing_d = missing_q + {24'd0, seq_jump};
      end
      seq_known_d = 1'b1;
      exp_seq_d   = req_i.sequence_req + 8'd1;
      // offset and its range
      offset_d = new_off;
      if (new_off < off_min_q) off_min_d = new_off;
      if (new_off > off_max_q) off_max_d = new_off;
      // deltas and skew from the second anchor on
      if (times_known_q) begin
        md_d   = new_md;
        ld_d   = new_ld;
        skew_d = new_skew;
        if (new_md > peak_md_q) peak_md_d = new_md;
        if (new_skew < skew_min_q) skew_min_d = new_skew;
        if (new_skew > skew_max_q) skew_max_d = new_skew;
      end
      times_known_d = 1'b1;
      prev_m_d      = req_i.master_time;
      prev_l_d      = req_i.local_time;
    end
  end

  // state registers, advanced once per request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_known_q   <= 1'b0;
      exp_seq_q     <= 8'd0;
      times_known_q <= 1'b0;
      prev_m_q      <= 32'd0;
      prev_l_q      <= 32'd0;
      offset_q      <= 32'sd0;
      off_min_q     <= asst_pkg::S32Max;
      off_max_q     <= asst_pkg::S32Min;
      md_q          <= 32'sd0;
      ld_q          <= 32'sd0;
      skew_q        <= 32'sd0;
      skew_min_q    <= asst_pkg::S32Max;
      skew_max_q    <= asst_pkg::S32Min;
      peak_md_q     <= 32'sd0;
      gaps_q        <= 32'd0;
      missing_q     <= 32'd0;
    end else if (en_i) begin
      seq_known_q   <= seq_known_d;
      exp_seq_q     <= exp_seq_d;
      times_known_q <= times_known_d;
      prev_m_q      <= prev_m_d;
      prev_l_q      <= prev_l_d;
      offset_q      <= offset_d;
      off_min_q     <= off_min_d;
      off_max_q     <= off_max_d;
      md_q          <= md_d;
      ld_q          <= ld_d;
      skew_q        <= skew_d;
      skew_min_q    <= skew_min_d;
      skew_max_q    <= skew_max_d;
      peak_md_q     <= peak_md_d;
      gaps_q        <= gaps_d;
      missing_q     <= missing_d;
    end
  end

  // result shows the state after this request
  always_comb begin
    res_o.accepted         = ok_i;
    res_o.offset           = offset_d;
    res_o.offset_min       = off_min_d;
    res_o.offset_max       = off_max_d;
    res_o.master_delta     = md_d;
    res_o.local_delta      = ld_d;
    res_o.skew             = skew_d;
    res_o.skew_min         = skew_min_d;
    res_o.skew_max         = skew_max_d;
    res_o.max_master_delta = peak_md_d;
    res_o.gap_count        = gaps_d;
    res_o.missing_total    = missing_d;
  end

endmodule

FILE: sv/anchor_sync_statistics_tracker.sv
// Anchor sync statistics tracker.
// Input channel: in_valid_i / in_stall_o carry one packet header request
// (type, length, session tag, sequence, master time) plus the local
// receive time. Output channel: out_valid_o / out_stall_i carry one
// result per request: accepted flag, clock offset and its range, master
// and local deltas, skew and its range, peak master delta and the
// sequence gap counters. Rejected packets leave the statistics as they
// are and report the current values with accepted low.
// A request passes an input register, then the filter and statistics
// update into the result register. One request per cycle is sustained
// while the receiver does not stall; two chained subtracts and a compare
// between the input and result registers set the clock.
// When the receiver stalls, the result register holds and one more
// request waits in the input register; then in_stall_o rises.
// Reset clears both stages and returns all statistics to their start
// values (offset and skew ranges empty, counters at zero). session_tag
// is written through cfg_we_i / cfg_data_i; the user must write it only while idle (unenforced).
module anchor_sync_statistics_tracker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [7:0]     cfg_data_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  asst_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output asst_pkg::res_t out_res_o
);

  logic [7:0]     session_tag_q;
  logic           s1_valid_q;
  asst_pkg::req_t s1_req_q;
  logic           out_valid_q;
  asst_pkg::res_t out_res_q;
  asst_pkg::res_t res;
  logic           ok;
  logic           adv_out;
  logic           fire;

  // pipeline flow control
  assign adv_out    = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && adv_out;
  assign in_stall_o = s1_valid_q && !adv_out;

  // session tag register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      session_tag_q <= 8'd0;
    end else if (cfg_we_i) begin
      session_tag_q <= cfg_data_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_req_q <= in_req_i;
    end
  end

  asst_filter u_filter (
    .req_i         (s1_req_q),
    .session_tag_i (session_tag_q),
    .ok_o          (ok)
  );

  asst_stats u_stats (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (fire),
    .ok_i   (ok),
    .req_i  (s1_req_q),
    .res_o  (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_out) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

`ifndef SYNTHESIS
  // an accepted offset lies within the tracked range
  a_off_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.accepted |-> out_res_o.offset_min <= out_res_o.offset)
    else $error("offset below tracked minimum");
  a_off_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.accepted |-> out_res_o.offset_max >= out_res_o.offset)
    else $error("offset above tracked maximum");
  // input stalls only when the input and result registers are both full
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled with room in pipeline");
  // a request in the input register reaches the result register when it moves
  a_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("request lost between stages");
  // session tag only changes on a configuration write
  a_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_we_i |=> $stable(session_tag_q))
    else $error("session tag changed without write");
`endif

endmodule
